// ===== hw/rtl/timezone_dst_time_converter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the time zone converter
// Clocked property wrappers with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef TIMEZONE_DST_TIME_CONVERTER_UNIT_ASSERT_SVH
`define TIMEZONE_DST_TIME_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TZ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tzdst_pkg.sv =====
// ----------------------------------------------------------------------------
// tzdst_pkg
// Beat types, register indexes and timing constants of the time zone converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tzdst_pkg;

    // Input beat: direction and timestamp
    typedef struct packed {
        logic        operation;
        logic [31:0] seconds_in;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic signed [33:0] seconds_out;
        logic               daylight_active;
        logic               rule_unsupported;
    } t_out_beat;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_STD_OFFSET = 3'd0,
        CFG_DL_OFFSET  = 3'd1,
        CFG_STD_MONTH  = 3'd2,
        CFG_STD_WEEK   = 3'd3,
        CFG_STD_HOUR   = 3'd4,
        CFG_DL_MONTH   = 3'd5,
        CFG_DL_WEEK    = 3'd6,
        CFG_DL_HOUR    = 3'd7
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Reset values of the rule registers
    localparam logic signed [10:0] RST_STD_OFFSET = 11'sd480;
    localparam logic signed [10:0] RST_DL_OFFSET  = 11'sd420;
    localparam logic [3:0]         RST_STD_MONTH  = 4'd10;
    localparam logic [2:0]         RST_STD_WEEK   = 3'd5;
    localparam logic [4:0]         RST_STD_HOUR   = 5'd2;
    localparam logic [3:0]         RST_DL_MONTH   = 4'd4;
    localparam logic [2:0]         RST_DL_WEEK    = 3'd1;
    localparam logic [4:0]         RST_DL_HOUR    = 5'd2;

    // Clock edges from the accepting edge to the edge that takes the result
    localparam int TZ_LATENCY = 11;

endpackage

`default_nettype wire

// ===== hw/rtl/timezone_dst_time_converter_unit.sv =====
// ----------------------------------------------------------------------------
// timezone_dst_time_converter_unit
// Converts a seconds-since-1970 time between UTC and local time under a
// yearly daylight saving rule (Nth or last Sunday of a month at an hour).
// ----------------------------------------------------------------------------
// Usage:
//   Command beat: i_cmd (operation, seconds_in) is taken at a rising edge with
//   i_start high and o_busy low. o_busy is always low: the pipeline takes one
//   beat every cycle, with no gaps needed between beats.
//   Result beat: o_result is valid for exactly one cycle while o_valid is high,
//   in command order. The receiver cannot stall the block and none is needed.
//   o_valid, the last bit of the valid shift register, rises together with
//   the stage 11 result register. Throughput: one beat per cycle, set by the
//   eleven-stage pipeline; divisions by 86400, 1461, 3600 and 7 are registered
//   reciprocal multiplies of at most 26 bits. The user must write rule
//   registers via i_cfg_we / i_cfg_index / i_cfg_wdata only while no beat is
//   in flight; the block does not enforce it. The two rule stages read them.
//   Reset (synchronous, i_rst_n low) clears all pipeline valid bits, drops
//   every beat in flight and restores the rule registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module timezone_dst_time_converter_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    output logic                                     o_busy,
    input  wire tzdst_pkg::t_in_beat                 i_cmd,
    output logic                                     o_valid,
    output tzdst_pkg::t_out_beat                     o_result,
    input  wire logic                                i_cfg_we,
    input  wire logic [tzdst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tzdst_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    // Reciprocal constants, exact over the input range
    localparam logic [25:0] DAY_RECIP    = 26'd50903317;  // 2^35 / 675, secs>>7
    localparam logic [16:0] CYCLE_RECIP  = 17'd91868;     // 2^27 / 1461
    localparam logic [16:0] HOUR_RECIP   = 17'd74566;     // 2^28 / 3600
    localparam logic [16:0] WEEK_RECIP   = 17'd74899;     // 2^19 / 7
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [15:0] DAYS_4YR     = 16'd1461;
    localparam logic [10:0] DAYS_YEAR    = 11'd365;
    // 1968-03-01 to 1970-01-01 in days; 2100-03-01 in days since 1970
    localparam logic [15:0] EPOCH_SHIFT  = 16'd671;
    localparam logic [15:0] MAR_2100     = 16'd47541;
    // four-year cycle whose last year holds February 2100
    localparam logic [5:0]  CYCLE_2100   = 6'd32;
    localparam logic [15:0] THU_SHIFT    = 16'd4;   // 1970-01-01 was a Thursday
    localparam logic [16:0] SECS_PER_MIN = 17'd60;
    localparam logic [15:0] WEEK_DAYS    = 16'd7;
    localparam logic [3:0]  SUN_WRAP     = 4'd8;

    // first day of each month in a March-based year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [15:0] days;
    } t_s1;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [15:0] days;
        logic [31:0] prod;
        logic [15:0] d;
    } t_s2;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [15:0] days;
        logic [16:0] rem;
        logic [15:0] d;
        logic [5:0]  c;
    } t_s3;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [15:0] days;
        logic [4:0]  hour;
        logic [10:0] r;
        logic [5:0]  c;
    } t_s4;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [15:0] days;
        logic [4:0]  hour;
        logic [8:0]  doy;
        logic        leap;
    } t_s5;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [15:0] days;
        logic [4:0]  hour;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic        leap;
    } t_s6;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [4:0]  hour;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [15:0] x;
        logic [12:0] q;
        logic [4:0]  mlen;
    } t_s7;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic [4:0]  hour;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [5:0]  std_day;
        logic [5:0]  dl_day;
    } t_s8;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic        dst;
        logic        unsup;
        logic [10:0] off;
    } t_s9;

    typedef struct packed {
        logic        op;
        logic [31:0] secs;
        logic        dst;
        logic        unsup;
        logic [16:0] off60;
    } t_s10;

    // Length of a calendar month
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Day of month of the chosen Sunday, zero for a week outside 1..5
    function automatic logic [5:0] rule_day(input logic [2:0] week, input logic [3:0] fs,
                                            input logic [4:0] mlen);
        logic [5:0] step;
        logic [5:0] day;
        step = 6'({3'b000, week} - 6'd1) * 6'd7;
        day  = {2'b00, fs} + step;
        if (day > {1'b0, mlen}) begin
            day = day - 6'd7;
        end
        if (week < 3'd1 || week > 3'd5) begin
            day = 6'd0;
        end
        return day;
    endfunction

    // ---------------- rule registers ----------------
    logic signed [10:0] r_std_offset;
    logic signed [10:0] r_dl_offset;
    logic [3:0]         r_std_month;
    logic [2:0]         r_std_week;
    logic [4:0]         r_std_hour;
    logic [3:0]         r_dl_month;
    logic [2:0]         r_dl_week;
    logic [4:0]         r_dl_hour;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std_offset <= tzdst_pkg::RST_STD_OFFSET;
            r_dl_offset  <= tzdst_pkg::RST_DL_OFFSET;
            r_std_month  <= tzdst_pkg::RST_STD_MONTH;
            r_std_week   <= tzdst_pkg::RST_STD_WEEK;
            r_std_hour   <= tzdst_pkg::RST_STD_HOUR;
            r_dl_month   <= tzdst_pkg::RST_DL_MONTH;
            r_dl_week    <= tzdst_pkg::RST_DL_WEEK;
            r_dl_hour    <= tzdst_pkg::RST_DL_HOUR;
        end else if (i_cfg_we) begin
            unique case (tzdst_pkg::t_cfg_idx'(i_cfg_index))
                tzdst_pkg::CFG_STD_OFFSET: r_std_offset <= i_cfg_wdata;
                tzdst_pkg::CFG_DL_OFFSET:  r_dl_offset  <= i_cfg_wdata;
                tzdst_pkg::CFG_STD_MONTH:  r_std_month  <= i_cfg_wdata[3:0];
                tzdst_pkg::CFG_STD_WEEK:   r_std_week   <= i_cfg_wdata[2:0];
                tzdst_pkg::CFG_STD_HOUR:   r_std_hour   <= i_cfg_wdata[4:0];
                tzdst_pkg::CFG_DL_MONTH:   r_dl_month   <= i_cfg_wdata[3:0];
                tzdst_pkg::CFG_DL_WEEK:    r_dl_week    <= i_cfg_wdata[2:0];
                tzdst_pkg::CFG_DL_HOUR:    r_dl_hour    <= i_cfg_wdata[4:0];
            endcase
        end
    end

    // ---------------- valid bits ----------------
    logic        w_accept;
    logic [10:0] r_vld;

    assign o_busy   = 1'b0;   // a beat can enter every cycle
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:0], w_accept};
        end
    end

    // ---------------- stage 1: day number ----------------
    t_s1         r_s1;
    logic [50:0] w_day_prod;

    assign w_day_prod = 51'(i_cmd.seconds_in[31:7]) * 51'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        r_s1.op   <= i_cmd.operation;
        r_s1.secs <= i_cmd.seconds_in;
        r_s1.days <= w_day_prod[50:35];
    end

    // ---------------- stage 2: start of day, shifted epoch ----------------
    t_s2 r_s2;

    always_ff @(posedge i_clk) begin
        r_s2.op   <= r_s1.op;
        r_s2.secs <= r_s1.secs;
        r_s2.days <= r_s1.days;
        r_s2.prod <= 32'(r_s1.days) * 32'(SECS_PER_DAY);
        // skip the February 29 that 2100 lacks
        r_s2.d    <= r_s1.days + EPOCH_SHIFT + 16'(r_s1.days >= MAR_2100);
    end

    // ---------------- stage 3: seconds of day, four-year cycle ----------------
    t_s3         r_s3;
    logic [32:0] w_cyc_prod;

    assign w_cyc_prod = 33'(r_s2.d) * 33'(CYCLE_RECIP);

    always_ff @(posedge i_clk) begin
        r_s3.op   <= r_s2.op;
        r_s3.secs <= r_s2.secs;
        r_s3.days <= r_s2.days;
        r_s3.rem  <= 17'(r_s2.secs - r_s2.prod);
        r_s3.d    <= r_s2.d;
        r_s3.c    <= w_cyc_prod[32:27];
    end

    // ---------------- stage 4: hour, day within cycle ----------------
    t_s4         r_s4;
    logic [33:0] w_hour_prod;

    assign w_hour_prod = 34'(r_s3.rem) * 34'(HOUR_RECIP);

    always_ff @(posedge i_clk) begin
        r_s4.op   <= r_s3.op;
        r_s4.secs <= r_s3.secs;
        r_s4.days <= r_s3.days;
        r_s4.hour <= w_hour_prod[32:28];
        r_s4.r    <= 11'(r_s3.d - 16'(r_s3.c) * DAYS_4YR);
        r_s4.c    <= r_s3.c;
    end

    // ---------------- stage 5: year within cycle, day of year ----------------
    t_s5        r_s5;
    logic [1:0] w_yc;

    always_comb begin
        priority if (r_s4.r >= 11'd1095) begin
            w_yc = 2'd3;
        end else if (r_s4.r >= 11'd730) begin
            w_yc = 2'd2;
        end else if (r_s4.r >= 11'd365) begin
            w_yc = 2'd1;
        end else begin
            w_yc = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5.op   <= r_s4.op;
        r_s5.secs <= r_s4.secs;
        r_s5.days <= r_s4.days;
        r_s5.hour <= r_s4.hour;
        r_s5.doy  <= 9'(r_s4.r - 11'(w_yc) * DAYS_YEAR);
        // last year of a cycle owns February 29, except around 2100
        r_s5.leap <= (w_yc == 2'd3) && (r_s4.c != CYCLE_2100);
    end

    // ---------------- stage 6: month and day of month ----------------
    t_s6        r_s6;
    logic [3:0] w_mp;

    always_comb begin
        w_mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_s5.doy >= MONTH_START[i]) begin
                w_mp = 4'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6.op    <= r_s5.op;
        r_s6.secs  <= r_s5.secs;
        r_s6.days  <= r_s5.days;
        r_s6.hour  <= r_s5.hour;
        r_s6.month <= (w_mp < 4'd10) ? w_mp + 4'd3 : w_mp - 4'd9;
        r_s6.mday  <= 5'(r_s5.doy - MONTH_START[w_mp] + 9'd1);
        r_s6.leap  <= r_s5.leap;
    end

    // ---------------- stage 7: weekday of the 1st, month length ----------------
    t_s7         r_s7;
    logic [15:0] w_x;
    logic [32:0] w_wk_prod;

    assign w_x       = r_s6.days - 16'(r_s6.mday) + 16'd1 + THU_SHIFT;
    assign w_wk_prod = 33'(w_x) * 33'(WEEK_RECIP);

    always_ff @(posedge i_clk) begin
        r_s7.op    <= r_s6.op;
        r_s7.secs  <= r_s6.secs;
        r_s7.hour  <= r_s6.hour;
        r_s7.month <= r_s6.month;
        r_s7.mday  <= r_s6.mday;
        r_s7.x     <= w_x;
        r_s7.q     <= w_wk_prod[31:19];
        r_s7.mlen  <= month_len(r_s6.month, r_s6.leap);
    end

    // ---------------- stage 8: transition days ----------------
    t_s8        r_s8;
    logic [2:0] w_wf;
    logic [3:0] w_fs;

    assign w_wf = 3'(r_s7.x - 16'(r_s7.q) * WEEK_DAYS);
    assign w_fs = (w_wf == 3'd0) ? 4'd1 : SUN_WRAP - {1'b0, w_wf};

    always_ff @(posedge i_clk) begin
        r_s8.op      <= r_s7.op;
        r_s8.secs    <= r_s7.secs;
        r_s8.hour    <= r_s7.hour;
        r_s8.month   <= r_s7.month;
        r_s8.mday    <= r_s7.mday;
        r_s8.std_day <= rule_day(r_std_week, w_fs, r_s7.mlen);
        r_s8.dl_day  <= rule_day(r_dl_week, w_fs, r_s7.mlen);
    end

    // ---------------- stage 9: daylight decision ----------------
    t_s9        r_s9;
    logic       w_unsup;
    logic       w_dst;
    logic [5:0] w_mday;

    assign w_unsup = !(r_std_month > r_dl_month);
    assign w_mday  = {1'b0, r_s8.mday};

    always_comb begin
        priority if (w_unsup) begin
            w_dst = 1'b0;
        end else if (r_s8.month < r_dl_month || r_s8.month > r_std_month) begin
            w_dst = 1'b0;
        end else if (r_s8.month > r_dl_month && r_s8.month < r_std_month) begin
            w_dst = 1'b1;
        end else if (r_s8.month == r_std_month) begin
            // daylight runs until the standard transition hour
            priority if (w_mday < r_s8.std_day) begin
                w_dst = 1'b1;
            end else if (w_mday > r_s8.std_day) begin
                w_dst = 1'b0;
            end else begin
                w_dst = r_s8.hour < r_std_hour;
            end
        end else begin
            // daylight starts at the daylight transition hour
            priority if (w_mday < r_s8.dl_day) begin
                w_dst = 1'b0;
            end else if (w_mday > r_s8.dl_day) begin
                w_dst = 1'b1;
            end else begin
                w_dst = r_s8.hour >= r_dl_hour;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s9.op    <= r_s8.op;
        r_s9.secs  <= r_s8.secs;
        r_s9.dst   <= w_dst;
        r_s9.unsup <= w_unsup;
        r_s9.off   <= w_dst ? r_dl_offset : r_std_offset;
    end

    // ---------------- stage 10: offset in seconds ----------------
    t_s10               r_s10;
    logic signed [16:0] w_off_ext;

    assign w_off_ext = {{6{r_s9.off[10]}}, r_s9.off};

    always_ff @(posedge i_clk) begin
        r_s10.op    <= r_s9.op;
        r_s10.secs  <= r_s9.secs;
        r_s10.dst   <= r_s9.dst;
        r_s10.unsup <= r_s9.unsup;
        r_s10.off60 <= w_off_ext * $signed(SECS_PER_MIN);
    end

    // ---------------- stage 11: apply offset, result register ----------------
    tzdst_pkg::t_out_beat r_result;
    logic [33:0]          w_secs_ext;
    logic [33:0]          w_off_sec;

    assign w_secs_ext = {2'b00, r_s10.secs};
    assign w_off_sec  = {{17{r_s10.off60[16]}}, r_s10.off60};

    always_ff @(posedge i_clk) begin
        r_result.seconds_out      <= r_s10.op ? w_secs_ext + w_off_sec
                                              : w_secs_ext - w_off_sec;
        r_result.daylight_active  <= r_s10.dst;
        r_result.rule_unsupported <= r_s10.unsup;
    end

    assign o_valid  = r_vld[10];
    assign o_result = r_result;

    // ---------------- assertions ----------------
`include "timezone_dst_time_converter_unit_assert.svh"

    `TZ_ASSERT_IMPL(a_latency, i_clk, i_rst_n, w_accept, ##(tzdst_pkg::TZ_LATENCY) o_valid, "result beat missing after command")
    `TZ_ASSERT_IMPL(a_unsup_std, i_clk, i_rst_n, o_valid && o_result.rule_unsupported, !o_result.daylight_active, "daylight applied under unsupported rule")
    `TZ_ASSERT_IMPL(a_dst_window, i_clk, i_rst_n, r_vld[7] && w_dst, (r_s8.month >= r_dl_month) && (r_s8.month <= r_std_month), "daylight outside rule months")
    `TZ_ASSERT_NEXT(a_off_select, i_clk, i_rst_n, r_vld[7], r_s9.off == (r_s9.dst ? r_dl_offset : r_std_offset), "offset does not match decision")

endmodule

`default_nettype wire

// ===== tb/sv/timezone_dst_time_converter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// timezone_dst_time_converter_unit_tb
// Self-checking bench for the UTC/local time converter. An in-bench calendar
// model predicts every result beat from the command beat and the current
// rule registers. Directed cases cover the rule transitions, unsupported and
// out-of-range rule fields and offset extremes. Random phases then follow,
// each under a fresh rule, with the sender idling at several rates.
// ----------------------------------------------------------------------------
module timezone_dst_time_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_TO_LOCAL = 1'b0;
    localparam logic OP_TO_UTC   = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;

    // Rule register image kept by the bench
    typedef struct {
        logic signed [10:0] std_off;
        logic signed [10:0] dl_off;
        logic [3:0]         std_mon;
        logic [2:0]         std_wk;
        logic [4:0]         std_hr;
        logic [3:0]         dl_mon;
        logic [2:0]         dl_wk;
        logic [4:0]         dl_hr;
    } t_tz_rule;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_start     = 1'b0;
    tzdst_pkg::t_in_beat              i_cmd       = '0;
    logic                             i_cfg_we    = 1'b0;
    logic [tzdst_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tzdst_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                             o_busy;
    logic                             o_valid;
    tzdst_pkg::t_out_beat             o_result;

    t_tz_rule             active_rule;
    tzdst_pkg::t_out_beat pending_results[$];
    int                   mismatch_count = 0;

    timezone_dst_time_converter_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Calendar helpers
    // ------------------------------------------------------------------------
    function automatic t_tz_rule default_rule();
        t_tz_rule r;
        r.std_off = tzdst_pkg::RST_STD_OFFSET;
        r.dl_off  = tzdst_pkg::RST_DL_OFFSET;
        r.std_mon = tzdst_pkg::RST_STD_MONTH;
        r.std_wk  = tzdst_pkg::RST_STD_WEEK;
        r.std_hr  = tzdst_pkg::RST_STD_HOUR;
        r.dl_mon  = tzdst_pkg::RST_DL_MONTH;
        r.dl_wk   = tzdst_pkg::RST_DL_WEEK;
        r.dl_hr   = tzdst_pkg::RST_DL_HOUR;
        return r;
    endfunction

    function automatic int unsigned month_days(int unsigned year, int unsigned month);
        logic leap;
        leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        case (month)
            2:            return leap ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Day of the Nth Sunday (5 = last); 0 when the week is out of range
    function automatic int unsigned nth_sunday(int unsigned wk, int unsigned first_wd,
                                               int unsigned mlen);
        int unsigned d;
        if (wk < 1 || wk > 5)
            return 0;
        d = 1 + (7 - first_wd) % 7 + (wk - 1) * 7;
        while (d > mlen)
            d -= 7;
        return d;
    endfunction

    // Days from 1970-01-01 to a civil date
    function automatic longint epoch_days(int y, int m, int d);
        int yy, era, yoe, mp, doy, doe;
        yy  = (m <= 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (m + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return longint'(era) * 146097 + doe - 719468;
    endfunction

    function automatic longint date_secs(int y, int m, int d, int h);
        return epoch_days(y, m, d) * 86400 + h * 3600;
    endfunction

    function automatic int transition_day(int y, int m, int wk);
        return nth_sunday(wk, int'((epoch_days(y, m, 1) + 4) % 7), month_days(y, m));
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: converted time under the active rule
    // ------------------------------------------------------------------------
    function automatic tzdst_pkg::t_out_beat convert_time(tzdst_pkg::t_in_beat cmd);
        int unsigned          days, hour, wday, z, era, doe, yoe, doy, mp;
        int unsigned          mday, month, year, mlen, tday;
        logic                 unsupported, dst;
        longint               off_min, secs_l, res;
        tzdst_pkg::t_out_beat out;

        days = cmd.seconds_in / 86400;
        hour = (cmd.seconds_in % 86400) / 3600;
        wday = (days + 4) % 7;

        // civil date from day count
        z     = days + 719468;
        era   = z / 146097;
        doe   = z - era * 146097;
        yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp    = (5 * doy + 2) / 153;
        mday  = doy - (153 * mp + 2) / 5 + 1;
        month = (mp < 10) ? mp + 3 : mp - 9;
        year  = yoe + era * 400 + ((month <= 2) ? 1 : 0);

        unsupported = !(active_rule.std_mon > active_rule.dl_mon);
        dst = 1'b0;
        if (!unsupported) begin
            mlen = month_days(year, month);
            if (month < active_rule.dl_mon || month > active_rule.std_mon) begin
                dst = 1'b0;
            end else if (month > active_rule.dl_mon && month < active_rule.std_mon) begin
                dst = 1'b1;
            end else if (month == active_rule.std_mon) begin
                tday = nth_sunday(active_rule.std_wk, (wday + 35 - (mday - 1)) % 7, mlen);
                if (mday < tday)
                    dst = 1'b1;
                else if (mday > tday)
                    dst = 1'b0;
                else
                    dst = (hour < active_rule.std_hr);
            end else begin
                tday = nth_sunday(active_rule.dl_wk, (wday + 35 - (mday - 1)) % 7, mlen);
                if (mday < tday)
                    dst = 1'b0;
                else if (mday > tday)
                    dst = 1'b1;
                else
                    dst = (hour >= active_rule.dl_hr);
            end
        end

        if (dst)
            off_min = active_rule.dl_off;
        else
            off_min = active_rule.std_off;
        secs_l = cmd.seconds_in;
        res = (cmd.operation == OP_TO_UTC) ? secs_l + off_min * 60 : secs_l - off_min * 60;

        out.seconds_out      = res[33:0];
        out.daylight_active  = dst;
        out.rule_unsupported = unsupported;
        return out;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        tzdst_pkg::t_out_beat want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: %p", o_result);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.seconds_out !== want.seconds_out) begin
                    $error("seconds_out: expected %0d, got %0d",
                           want.seconds_out, o_result.seconds_out);
                    mismatch_count++;
                end
                if (o_result.daylight_active !== want.daylight_active) begin
                    $error("daylight_active: expected %0b, got %0b",
                           want.daylight_active, o_result.daylight_active);
                    mismatch_count++;
                end
                if (o_result.rule_unsupported !== want.rule_unsupported) begin
                    $error("rule_unsupported: expected %0b, got %0b",
                           want.rule_unsupported, o_result.rule_unsupported);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One command beat; start is left high for a following beat
    task automatic send_conversion(input logic op, input logic [31:0] secs);
        tzdst_pkg::t_in_beat beat;
        beat.operation  = op;
        beat.seconds_in = secs;
        i_start <= 1'b1;
        i_cmd   <= beat;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        pending_results.push_back(convert_time(beat));
    endtask

    // One command beat from a computed time
    task automatic send_time(input logic op, input longint secs);
        send_conversion(op, secs[31:0]);
    endtask

    task automatic send_both(input longint secs);
        send_time(OP_TO_LOCAL, secs);
        send_time(OP_TO_UTC, secs);
    endtask

    // Drop start, let all results arrive, then allow the pipeline to empty
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (tzdst_pkg::TZ_LATENCY + 4) @(posedge i_clk);
    endtask

    // Write all rule registers; junk in the unused upper bits of narrow ones
    task automatic load_rule(input t_tz_rule r);
        tzdst_pkg::t_cfg_idx              idx;
        logic [tzdst_pkg::CFG_DATA_W-1:0] data;
        logic [31:0]                      rnd;
        idx = idx.first();
        repeat (idx.num()) begin
            rnd  = $urandom;
            data = rnd[tzdst_pkg::CFG_DATA_W-1:0];
            case (idx)
                tzdst_pkg::CFG_STD_OFFSET: data      = r.std_off;
                tzdst_pkg::CFG_DL_OFFSET:  data      = r.dl_off;
                tzdst_pkg::CFG_STD_MONTH:  data[3:0] = r.std_mon;
                tzdst_pkg::CFG_STD_WEEK:   data[2:0] = r.std_wk;
                tzdst_pkg::CFG_STD_HOUR:   data[4:0] = r.std_hr;
                tzdst_pkg::CFG_DL_MONTH:   data[3:0] = r.dl_mon;
                tzdst_pkg::CFG_DL_WEEK:    data[2:0] = r.dl_wk;
                tzdst_pkg::CFG_DL_HOUR:    data[4:0] = r.dl_hr;
                default:                   data      = '0;
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= data;
            @(posedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
        active_rule = r;
    endtask

    function automatic t_tz_rule random_rule();
        t_tz_rule r;
        if ($urandom_range(0, 4) != 0) begin
            // well-formed northern-style rule
            r.dl_mon  = 4'($urandom_range(1, 11));
            r.std_mon = 4'($urandom_range(r.dl_mon + 1, 12));
            r.dl_wk   = 3'($urandom_range(1, 5));
            r.std_wk  = 3'($urandom_range(1, 5));
            r.dl_hr   = 5'($urandom_range(0, 23));
            r.std_hr  = 5'($urandom_range(0, 23));
            r.std_off = 11'($urandom_range(0, 1680) - 840);
            r.dl_off  = 11'($urandom_range(0, 1680) - 840);
        end else begin
            r.std_off = 11'($urandom);
            r.dl_off  = 11'($urandom);
            r.std_mon = 4'($urandom);
            r.std_wk  = 3'($urandom);
            r.std_hr  = 5'($urandom);
            r.dl_mon  = 4'($urandom);
            r.dl_wk   = 3'($urandom);
            r.dl_hr   = 5'($urandom);
        end
        return r;
    endfunction

    // Random beats, mostly clustered around the rule's transitions
    task automatic random_items(input int n, input int idle_pct);
        int          sel, y, m, d, hr, wk;
        longint      s;
        logic [31:0] secs;
        for (int i = 0; i < n; i++) begin
            sel = int'($urandom_range(0, 9));
            if (sel < 3) begin
                secs = $urandom;
            end else if (sel == 3) begin
                if ($urandom_range(0, 1))
                    secs = $urandom_range(0, 200000);
                else
                    secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
            end else begin
                y  = int'($urandom_range(1970, 2105));
                m  = (sel < 6) ? int'(active_rule.dl_mon) :
                     (sel < 8) ? int'(active_rule.std_mon) : int'($urandom_range(1, 12));
                if (m < 1 || m > 12)
                    m = int'($urandom_range(1, 12));
                wk = (sel < 6) ? int'(active_rule.dl_wk) : int'(active_rule.std_wk);
                hr = (sel < 6) ? int'(active_rule.dl_hr) : int'(active_rule.std_hr);
                d  = transition_day(y, m, wk);
                if (d == 0 || $urandom_range(0, 3) == 0) begin
                    d = int'($urandom_range(1, month_days(y, m)));
                end else begin
                    d = d + int'($urandom_range(0, 2)) - 1;
                    if (d < 1)
                        d = 1;
                    if (d > int'(month_days(y, m)))
                        d = int'(month_days(y, m));
                end
                if (hr > 23 || $urandom_range(0, 3) == 0)
                    hr = int'($urandom_range(0, 23));
                else if (hr > 0 && $urandom_range(0, 1))
                    hr = hr - 1;
                s = date_secs(y, m, d, hr);
                case ($urandom_range(0, 2))
                    0:       s = s;
                    1:       s = s + 3599;
                    default: s = s + $urandom_range(0, 3599);
                endcase
                if (s < 0 || s > 64'hFFFF_FFFF)
                    secs = $urandom;
                else
                    secs = s[31:0];
            end

            // sender idle cycles at the phase's rate
            while (int'($urandom_range(0, 99)) < idle_pct) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
            send_conversion(logic'($urandom_range(0, 1)), secs);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset rule: first Sunday of April to last Sunday of October, 02:00
    task automatic test_reset_rule();
        int apr, oct;
        apr = transition_day(2024, 4, 1);
        oct = transition_day(2024, 10, 5);
        send_both(0);
        send_both(64'hFFFF_FFFF);
        send_both(date_secs(2024, 4, apr, 2) - 1);
        send_both(date_secs(2024, 4, apr, 2));
        send_both(date_secs(2024, 10, oct, 2) - 1);
        send_both(date_secs(2024, 10, oct, 2));
        send_time(OP_TO_LOCAL, date_secs(2024, 4, apr - 1, 12));
        send_time(OP_TO_UTC, date_secs(2024, 4, apr + 1, 0));
        send_time(OP_TO_LOCAL, date_secs(2024, 10, oct - 1, 23));
        send_time(OP_TO_UTC, date_secs(2024, 3, 31, 23) + 3599);
        send_time(OP_TO_LOCAL, date_secs(2024, 11, 1, 0));
        send_time(OP_TO_UTC, date_secs(2024, 7, 15, 12));
        // leap and century boundaries
        send_time(OP_TO_LOCAL, date_secs(2024, 2, 29, 6));
        send_time(OP_TO_UTC, date_secs(2000, 2, 29, 0));
        send_time(OP_TO_LOCAL, date_secs(2100, 3, 1, 0));
        send_time(OP_TO_UTC, date_secs(2099, 12, 31, 23) + 3599);
        wait_idle();
    endtask

    // Standard month not after the daylight month: always standard offset
    task automatic test_unsupported_rule();
        t_tz_rule r;
        r = default_rule();
        r.std_off = 11'sd600;
        r.dl_off  = 11'sd540;
        r.std_mon = 4'd4;
        r.dl_mon  = 4'd10;
        load_rule(r);
        send_both(date_secs(2023, 1, 10, 5));
        send_both(date_secs(2023, 4, transition_day(2023, 4, 5), 2));
        send_both(date_secs(2023, 7, 4, 12));
        send_both(date_secs(2023, 10, transition_day(2023, 10, 1), 2));
        wait_idle();
        r.std_mon = 4'd7;
        r.dl_mon  = 4'd7;
        load_rule(r);
        send_both(date_secs(2031, 7, 1, 0));
        send_both(date_secs(2031, 7, 31, 23) + 3599);
        random_items(40, 0);
    endtask

    // Weeks, months and hours outside their normal ranges
    task automatic test_odd_rule_fields();
        t_tz_rule r;
        int       t;
        // months 0 and 13: every real month lies between them
        r.std_off = 11'(-60);
        r.dl_off  = 11'(-120);
        r.std_mon = 4'd13;
        r.std_wk  = 3'd6;
        r.std_hr  = 5'd31;
        r.dl_mon  = 4'd0;
        r.dl_wk   = 3'd7;
        r.dl_hr   = 5'd24;
        load_rule(r);
        send_time(OP_TO_LOCAL, date_secs(2022, 1, 1, 0));
        send_time(OP_TO_UTC, date_secs(2022, 12, 31, 23));
        wait_idle();
        // week 0 and 7: transition at the first moment of the month
        r.dl_mon  = 4'd3;
        r.dl_wk   = 3'd0;
        r.dl_hr   = 5'd5;
        r.std_mon = 4'd11;
        r.std_wk  = 3'd7;
        r.std_hr  = 5'd0;
        load_rule(r);
        send_time(OP_TO_LOCAL, date_secs(2028, 3, 1, 0) - 1);
        send_time(OP_TO_UTC, date_secs(2028, 3, 1, 0));
        send_time(OP_TO_LOCAL, date_secs(2028, 11, 1, 0) - 1);
        send_time(OP_TO_UTC, date_secs(2028, 11, 1, 0));
        wait_idle();
        // hours 24..31 are never reached on the transition day
        r.dl_mon  = 4'd5;
        r.dl_wk   = 3'd2;
        r.dl_hr   = 5'd31;
        r.std_mon = 4'd9;
        r.std_wk  = 3'd3;
        r.std_hr  = 5'd24;
        load_rule(r);
        t = transition_day(2033, 5, 2);
        send_time(OP_TO_LOCAL, date_secs(2033, 5, t, 23) + 3599);
        send_time(OP_TO_UTC, date_secs(2033, 5, t + 1, 0));
        t = transition_day(2033, 9, 3);
        send_time(OP_TO_LOCAL, date_secs(2033, 9, t, 23) + 3599);
        send_time(OP_TO_UTC, date_secs(2033, 9, t + 1, 0));
        wait_idle();
    endtask

    // Offsets at the 11-bit limits and at the usual +/-14 hours
    task automatic test_offset_extremes();
        t_tz_rule r;
        r = default_rule();
        r.std_off = 11'(-1024);
        r.dl_off  = 11'sd1023;
        load_rule(r);
        send_both(0);
        send_both(64'hFFFF_FFFF);
        send_both(date_secs(2050, 7, 1, 0));
        wait_idle();
        r.std_off = 11'sd840;
        r.dl_off  = 11'(-840);
        load_rule(r);
        send_both(0);
        send_both(64'hFFFF_FFFF);
        send_both(date_secs(2050, 7, 1, 0));
        wait_idle();
    endtask

    // Random rules and items at several sender idle rates
    task automatic test_random_rules();
        int idle_rates[6] = '{0, 84, 28, 0, 84, 28};
        foreach (idle_rates[k]) begin
            load_rule(random_rule());
            random_items(135, idle_rates[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        active_rule = default_rule();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_rule();
        test_unsupported_rule();
        test_odd_rule_fields();
        test_offset_extremes();
        test_random_rules();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
